### rtl/kta_pkg.sv
// kta_pkg: shared types, key codes and character ROM lookups for the keycode translator.
// Depends on nothing; used by kta_xlate and keycode_to_ascii_translator_top.
`timescale 1ns / 1ps

package kta_pkg;

    typedef struct packed {
        logic shift;
        logic ctrl;
    } t_mods;

    localparam logic [15:0] EVT_KEY     = 16'd1;
    localparam logic [31:0] VAL_PRESS   = 32'd1;

    localparam logic [15:0] CODE_ESC    = 16'd1;
    localparam logic [15:0] CODE_ENTER  = 16'd28;
    localparam logic [15:0] CODE_LCTRL  = 16'd29;
    localparam logic [15:0] CODE_LSHIFT = 16'd42;
    localparam logic [15:0] CODE_RSHIFT = 16'd54;
    localparam logic [15:0] CODE_SPACE  = 16'd57;
    localparam logic [15:0] CODE_RCTRL  = 16'd97;
    localparam logic [15:0] CODE_UP     = 16'd103;
    localparam logic [15:0] CODE_LEFT   = 16'd105;
    localparam logic [15:0] CODE_RIGHT  = 16'd106;
    localparam logic [15:0] CODE_DOWN   = 16'd108;

    localparam logic [8:0] CHAR_UP    = 9'h100;
    localparam logic [8:0] CHAR_DOWN  = 9'h101;
    localparam logic [8:0] CHAR_LEFT  = 9'h102;
    localparam logic [8:0] CHAR_RIGHT = 9'h103;
    localparam logic [8:0] CHAR_LF    = 9'd10;
    localparam logic [8:0] CHAR_SPACE = 9'd32;
    localparam logic [8:0] CHAR_ESC   = 9'd27;

    function automatic logic [6:0] plain_rom(input logic [7:0] idx);
        logic [6:0] ch;
        case (idx)
            8'd1:  ch = 7'd27;
            8'd2:  ch = 7'd49;
            8'd3:  ch = 7'd50;
            8'd4:  ch = 7'd51;
            8'd5:  ch = 7'd52;
            8'd6:  ch = 7'd53;
            8'd7:  ch = 7'd54;
            8'd8:  ch = 7'd55;
            8'd9:  ch = 7'd56;
            8'd10: ch = 7'd57;
            8'd11: ch = 7'd48;
            8'd12: ch = 7'd45;
            8'd13: ch = 7'd61;
            8'd14: ch = 7'd8;
            8'd15: ch = 7'd9;
            8'd16: ch = 7'd113;
            8'd17: ch = 7'd119;
            8'd18: ch = 7'd101;
            8'd19: ch = 7'd114;
            8'd20: ch = 7'd116;
            8'd21: ch = 7'd121;
            8'd22: ch = 7'd117;
            8'd23: ch = 7'd105;
            8'd24: ch = 7'd111;
            8'd25: ch = 7'd112;
            8'd26: ch = 7'd91;
            8'd27: ch = 7'd93;
            8'd28: ch = 7'd10;
            8'd30: ch = 7'd97;
            8'd31: ch = 7'd115;
            8'd32: ch = 7'd100;
            8'd33: ch = 7'd102;
            8'd34: ch = 7'd103;
            8'd35: ch = 7'd104;
            8'd36: ch = 7'd106;
            8'd37: ch = 7'd107;
            8'd38: ch = 7'd108;
            8'd39: ch = 7'd59;
            8'd40: ch = 7'd39;
            8'd41: ch = 7'd96;
            8'd43: ch = 7'd92;
            8'd44: ch = 7'd122;
            8'd45: ch = 7'd120;
            8'd46: ch = 7'd99;
            8'd47: ch = 7'd118;
            8'd48: ch = 7'd98;
            8'd49: ch = 7'd110;
            8'd50: ch = 7'd109;
            8'd51: ch = 7'd44;
            8'd52: ch = 7'd46;
            8'd53: ch = 7'd47;
            8'd55: ch = 7'd42;
            8'd57: ch = 7'd32;
            8'd71: ch = 7'd55;
            8'd72: ch = 7'd56;
            8'd73: ch = 7'd57;
            8'd74: ch = 7'd45;
            8'd75: ch = 7'd52;
            8'd76: ch = 7'd53;
            8'd77: ch = 7'd54;
            8'd78: ch = 7'd43;
            8'd79: ch = 7'd49;
            8'd80: ch = 7'd50;
            8'd81: ch = 7'd51;
            8'd82: ch = 7'd48;
            8'd83: ch = 7'd46;
            default: ch = 7'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] shift_rom(input logic [7:0] idx);
        logic [6:0] ch;
        case (idx)
            8'd1:  ch = 7'd27;
            8'd2:  ch = 7'd33;
            8'd3:  ch = 7'd64;
            8'd4:  ch = 7'd35;
            8'd5:  ch = 7'd36;
            8'd6:  ch = 7'd37;
            8'd7:  ch = 7'd94;
            8'd8:  ch = 7'd38;
            8'd9:  ch = 7'd42;
            8'd10: ch = 7'd40;
            8'd11: ch = 7'd41;
            8'd12: ch = 7'd95;
            8'd13: ch = 7'd43;
            8'd14: ch = 7'd8;
            8'd15: ch = 7'd9;
            8'd16: ch = 7'd81;
            8'd17: ch = 7'd87;
            8'd18: ch = 7'd69;
            8'd19: ch = 7'd82;
            8'd20: ch = 7'd84;
            8'd21: ch = 7'd89;
            8'd22: ch = 7'd85;
            8'd23: ch = 7'd73;
            8'd24: ch = 7'd79;
            8'd25: ch = 7'd80;
            8'd26: ch = 7'd123;
            8'd27: ch = 7'd125;
            8'd28: ch = 7'd10;
            8'd30: ch = 7'd65;
            8'd31: ch = 7'd83;
            8'd32: ch = 7'd68;
            8'd33: ch = 7'd70;
            8'd34: ch = 7'd71;
            8'd35: ch = 7'd72;
            8'd36: ch = 7'd74;
            8'd37: ch = 7'd75;
            8'd38: ch = 7'd76;
            8'd39: ch = 7'd58;
            8'd40: ch = 7'd34;
            8'd41: ch = 7'd126;
            8'd43: ch = 7'd124;
            8'd44: ch = 7'd90;
            8'd45: ch = 7'd88;
            8'd46: ch = 7'd67;
            8'd47: ch = 7'd86;
            8'd48: ch = 7'd66;
            8'd49: ch = 7'd78;
            8'd50: ch = 7'd77;
            8'd51: ch = 7'd60;
            8'd52: ch = 7'd62;
            8'd53: ch = 7'd63;
            8'd55: ch = 7'd42;
            8'd57: ch = 7'd32;
            8'd71: ch = 7'd55;
            8'd72: ch = 7'd56;
            8'd73: ch = 7'd57;
            8'd74: ch = 7'd45;
            8'd75: ch = 7'd52;
            8'd76: ch = 7'd53;
            8'd77: ch = 7'd54;
            8'd78: ch = 7'd43;
            8'd79: ch = 7'd49;
            8'd80: ch = 7'd50;
            8'd81: ch = 7'd51;
            8'd82: ch = 7'd48;
            8'd83: ch = 7'd46;
            default: ch = 7'd0;
        endcase
        return ch;
    endfunction

endpackage

### rtl/kta_xlate.sv
// kta_xlate: combinational key code to character mapping with modifier handling.
// Depends on kta_pkg (key codes, character codes, ROM functions, t_mods).
`timescale 1ns / 1ps

module kta_xlate #(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic [15:0]       i_key_code,
    input  kta_pkg::t_mods    i_mods,
    output logic [8:0]        o_char
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [7:0] rom_idx;
    logic [6:0] plain_ch;
    logic [6:0] shift_ch;
    logic       in_table;

    assign in_table = i_key_code < 16'(TABLE_ENTRIES);
    assign rom_idx  = 8'(i_key_code[IDX_W-1:0]);
    assign plain_ch = kta_pkg::plain_rom(rom_idx);
    assign shift_ch = kta_pkg::shift_rom(rom_idx);

    always_comb begin
        o_char = 9'd0;
        case (i_key_code)
            kta_pkg::CODE_UP:     o_char = kta_pkg::CHAR_UP;
            kta_pkg::CODE_DOWN:   o_char = kta_pkg::CHAR_DOWN;
            kta_pkg::CODE_LEFT:   o_char = kta_pkg::CHAR_LEFT;
            kta_pkg::CODE_RIGHT:  o_char = kta_pkg::CHAR_RIGHT;
            kta_pkg::CODE_LCTRL,
            kta_pkg::CODE_RCTRL,
            kta_pkg::CODE_LSHIFT,
            kta_pkg::CODE_RSHIFT: o_char = 9'd0;
            kta_pkg::CODE_ENTER:  o_char = kta_pkg::CHAR_LF;
            kta_pkg::CODE_SPACE:  o_char = kta_pkg::CHAR_SPACE;
            kta_pkg::CODE_ESC:    o_char = kta_pkg::CHAR_ESC;
            default: begin
                if (!in_table) begin
                    o_char = 9'd0;
                end else if (i_mods.ctrl) begin
                    // fold letters to control codes 1-26
                    if (plain_ch >= 7'd97 && plain_ch <= 7'd122) begin
                        o_char = 9'(plain_ch - 7'd96);
                    end else if (plain_ch >= 7'd65 && plain_ch <= 7'd90) begin
                        o_char = 9'(plain_ch - 7'd64);
                    end else begin
                        o_char = 9'd0;
                    end
                end else if (i_mods.shift) begin
                    o_char = 9'(shift_ch);
                end else begin
                    o_char = 9'(plain_ch);
                end
            end
        endcase
    end

endmodule

### rtl/keycode_to_ascii_translator_top.sv
// keycode_to_ascii_translator_top: input register, modifier flags, translation and
// result register. Depends on kta_pkg and kta_xlate.
//
//   channel | direction | handshake                  | payload
//   in      | request in| i_in_valid / o_in_stall     | i_event_type, i_key_code, i_key_value
//   out     | result out| o_out_valid / i_out_stall   | o_char_out
//
// One request per cycle unless stalled; results are registered after the input register.
// The translation path is the ROM lookup plus ctrl folding between the two registers.
// Synchronous active-low reset clears both valids and the shift and ctrl flags.
// A stalled result holds the pipe; requests that give no result still wait their turn.
`timescale 1ns / 1ps

module keycode_to_ascii_translator_top #(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_event_type,
    input  logic [15:0] i_key_code,
    input  logic [31:0] i_key_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [8:0]  o_char_out
);

    logic        r_in_valid;
    logic [15:0] r_event_type;
    logic [15:0] r_key_code;
    logic [31:0] r_key_value;
    logic        r_out_valid;
    logic [8:0]  r_char;
    kta_pkg::t_mods r_mods;
    kta_pkg::t_mods n_mods;

    logic       out_free;
    logic       advance;
    logic       accept;
    logic       is_key;
    logic       emit;
    logic [8:0] xl_char;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign is_key = r_event_type == kta_pkg::EVT_KEY;

    kta_xlate #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_xlate (
        .i_key_code (r_key_code),
        .i_mods     (r_mods),
        .o_char     (xl_char)
    );

    assign emit = is_key && (r_key_value == kta_pkg::VAL_PRESS) && (xl_char != 9'd0);

    always_comb begin
        n_mods = r_mods;
        if (is_key) begin
            if (r_key_code == kta_pkg::CODE_LSHIFT || r_key_code == kta_pkg::CODE_RSHIFT) begin
                n_mods.shift = r_key_value != 32'd0;
            end
            if (r_key_code == kta_pkg::CODE_LCTRL || r_key_code == kta_pkg::CODE_RCTRL) begin
                n_mods.ctrl = r_key_value != 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mods      <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_mods      <= n_mods;
                r_out_valid <= emit;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event_type <= i_event_type;
            r_key_code   <= i_key_code;
            r_key_value  <= i_key_value;
        end
        if (advance && emit) begin
            r_char <= xl_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_out  = r_char;

endmodule

### tb/tb_keycode_to_ascii_translator_top.sv
// tb_keycode_to_ascii_translator_top: self-checking bench for the keycode translator.
// Drives directed and random key events, predicts characters from its own modifier
// state and character maps; depends on kta_pkg and keycode_to_ascii_translator_top.
`timescale 1ns / 1ps

module tb_keycode_to_ascii_translator_top;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int ROM_SPAN       = 128;
    localparam int MAP_FILLED     = 84;
    localparam int REQS_PER_PHASE = 488;
    localparam int DRAIN_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 200000;

    localparam logic [15:0] KEY_1        = 16'd2;
    localparam logic [15:0] KEY_Q        = 16'd16;
    localparam logic [15:0] KEY_A        = 16'd30;
    localparam logic [15:0] KEY_Z        = 16'd44;
    localparam logic [15:0] KEY_SLASH    = 16'd53;
    localparam logic [15:0] KEY_ROM_LAST = 16'd127;
    localparam logic [15:0] KEY_ROM_OUT  = 16'd128;
    localparam logic [15:0] KEY_MAX      = 16'hFFFF;
    localparam logic [15:0] EVT_NONE     = 16'd0;
    localparam logic [15:0] EVT_MAX      = 16'hFFFF;
    localparam logic [31:0] VAL_RELEASE  = 32'd0;
    localparam logic [31:0] VAL_REPEAT   = 32'd2;
    localparam logic [31:0] VAL_MAX      = 32'hFFFF_FFFF;
    localparam logic [8:0]  CHAR_NONE    = 9'd0;
    localparam logic [8:0]  CHAR_A       = 9'd97;

    typedef struct packed {
        logic [15:0] ev;
        logic [15:0] code;
        logic [31:0] val;
        logic        typed;
        logic [8:0]  ch;
    } t_key_row;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_event_type = '0;
    logic [15:0] i_key_code   = '0;
    logic [31:0] i_key_value  = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [8:0]  o_char_out;

    logic [6:0] plain_map [0:MAP_FILLED-1] = '{
        0, 27, 49, 50, 51, 52, 53, 54,
        55, 56, 57, 48, 45, 61, 8, 9,
        113, 119, 101, 114, 116, 121, 117, 105,
        111, 112, 91, 93, 10, 0, 97, 115,
        100, 102, 103, 104, 106, 107, 108, 59,
        39, 96, 0, 92, 122, 120, 99, 118,
        98, 110, 109, 44, 46, 47, 0, 42,
        0, 32, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 55,
        56, 57, 45, 52, 53, 54, 43, 49,
        50, 51, 48, 46
    };
    logic [6:0] shifted_map [0:MAP_FILLED-1] = '{
        0, 27, 33, 64, 35, 36, 37, 94,
        38, 42, 40, 41, 95, 43, 8, 9,
        81, 87, 69, 82, 84, 89, 85, 73,
        79, 80, 123, 125, 10, 0, 65, 83,
        68, 70, 71, 72, 74, 75, 76, 58,
        34, 126, 0, 124, 90, 88, 67, 86,
        66, 78, 77, 60, 62, 63, 0, 42,
        0, 32, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 55,
        56, 57, 45, 52, 53, 54, 43, 49,
        50, 51, 48, 46
    };
    logic [15:0] fixed_keys [0:10] = '{
        kta_pkg::CODE_ESC, kta_pkg::CODE_ENTER, kta_pkg::CODE_SPACE, kta_pkg::CODE_UP,
        kta_pkg::CODE_DOWN, kta_pkg::CODE_LEFT, kta_pkg::CODE_RIGHT,
        kta_pkg::CODE_LSHIFT, kta_pkg::CODE_RSHIFT, kta_pkg::CODE_LCTRL,
        kta_pkg::CODE_RCTRL
    };

    bit         pred_shift = 1'b0;
    bit         pred_ctrl  = 1'b0;
    logic [8:0] char_expect_q [$];
    t_key_row   key_rows [$];
    int         sender_idle_pct = 0;
    int         stall_pct       = 0;
    int         requests_sent   = 0;
    int         key_requests    = 0;
    int         chars_seen      = 0;
    int         typed_checks    = 0;
    int         mismatches      = 0;
    int         cycle_count     = 0;

    keycode_to_ascii_translator_top #(
        .TABLE_ENTRIES(ROM_SPAN)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_event_type(i_event_type),
        .i_key_code  (i_key_code),
        .i_key_value (i_key_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_char_out  (o_char_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void predict_char(input logic [15:0] ev, input logic [15:0] code,
                                         input logic [31:0] val, output logic [8:0] ch);
        logic [6:0] entry;
        ch = CHAR_NONE;
        entry = '0;
        if (ev != kta_pkg::EVT_KEY)
            return;
        if (code == kta_pkg::CODE_LSHIFT || code == kta_pkg::CODE_RSHIFT)
            pred_shift = (val != VAL_RELEASE);
        if (code == kta_pkg::CODE_LCTRL || code == kta_pkg::CODE_RCTRL)
            pred_ctrl = (val != VAL_RELEASE);
        if (val != kta_pkg::VAL_PRESS)
            return;
        case (code)
            kta_pkg::CODE_UP:    ch = kta_pkg::CHAR_UP;
            kta_pkg::CODE_DOWN:  ch = kta_pkg::CHAR_DOWN;
            kta_pkg::CODE_LEFT:  ch = kta_pkg::CHAR_LEFT;
            kta_pkg::CODE_RIGHT: ch = kta_pkg::CHAR_RIGHT;
            kta_pkg::CODE_ENTER: ch = kta_pkg::CHAR_LF;
            kta_pkg::CODE_SPACE: ch = kta_pkg::CHAR_SPACE;
            kta_pkg::CODE_ESC:   ch = kta_pkg::CHAR_ESC;
            kta_pkg::CODE_LSHIFT, kta_pkg::CODE_RSHIFT,
            kta_pkg::CODE_LCTRL, kta_pkg::CODE_RCTRL: ch = CHAR_NONE;
            default: begin
                if (code < MAP_FILLED) begin
                    if (pred_ctrl) begin
                        entry = plain_map[code[6:0]];
                        if (entry >= "a" && entry <= "z")
                            ch = 9'(entry - "a" + 1);
                        else if (entry >= "A" && entry <= "Z")
                            ch = 9'(entry - "A" + 1);
                    end else if (pred_shift) begin
                        ch = 9'(shifted_map[code[6:0]]);
                    end else begin
                        ch = 9'(plain_map[code[6:0]]);
                    end
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        mismatches++;
        $display("MISMATCH %s: got 0x%03h want 0x%03h at char %0d (t=%0t)",
                 what, got, want, chars_seen, $realtime);
    endtask

    task automatic add_row(input logic [15:0] ev, input logic [15:0] code,
                           input logic [31:0] val, input logic typed, input logic [8:0] ch);
        t_key_row row;
        row.ev = ev;
        row.code = code;
        row.val = val;
        row.typed = typed;
        row.ch = ch;
        key_rows.push_back(row);
    endtask

    // hold the request until taken, then queue what it should produce
    task automatic send_request(input logic [15:0] ev, input logic [15:0] code,
                                input logic [31:0] val, input logic typed,
                                input logic [8:0] typed_ch);
        logic [8:0] ch;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_event_type <= ev;
        i_key_code   <= code;
        i_key_value  <= val;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        requests_sent++;
        if (ev == kta_pkg::EVT_KEY)
            key_requests++;
        predict_char(ev, code, val, ch);
        if (typed) begin
            typed_checks++;
            ch = typed_ch;
        end
        if (ch != CHAR_NONE)
            char_expect_q.push_back(ch);
    endtask

    task automatic random_request(output logic [15:0] ev, output logic [15:0] code,
                                  output logic [31:0] val);
        int pick;
        pick = $urandom_range(99);
        ev = kta_pkg::EVT_KEY;
        if (pick < 8)
            ev = 16'($urandom_range(0, 65535));
        pick = $urandom_range(99);
        if (pick < 25)
            code = fixed_keys[$urandom_range(0, 10)];
        else if (pick < 90)
            code = 16'($urandom_range(0, ROM_SPAN - 1));
        else
            code = 16'($urandom_range(0, 65535));
        pick = $urandom_range(99);
        if (pick < 60)
            val = kta_pkg::VAL_PRESS;
        else if (pick < 80)
            val = VAL_RELEASE;
        else if (pick < 90)
            val = VAL_REPEAT;
        else
            val = $urandom;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (char_expect_q.size() == 0) begin
                report_mismatch("unexpected char", o_char_out, CHAR_NONE);
            end else begin
                if (o_char_out !== char_expect_q[0])
                    report_mismatch("char_out", o_char_out, char_expect_q[0]);
                void'(char_expect_q.pop_front());
            end
            chars_seen++;
        end
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chars outstanding",
                     cycle_count, char_expect_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [15:0] ev;
        logic [15:0] code;
        logic [31:0] val;
        int          sent_reqs;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(kta_pkg::EVT_KEY, KEY_A, kta_pkg::VAL_PRESS, 1'b1, CHAR_A);
        add_row(EVT_NONE, KEY_A, kta_pkg::VAL_PRESS, 1'b1, CHAR_NONE);
        add_row(EVT_MAX,  KEY_A, kta_pkg::VAL_PRESS, 1'b1, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_UP, kta_pkg::VAL_PRESS, 1'b1,
                kta_pkg::CHAR_UP);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_DOWN, kta_pkg::VAL_PRESS, 1'b1,
                kta_pkg::CHAR_DOWN);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_LEFT, kta_pkg::VAL_PRESS, 1'b1,
                kta_pkg::CHAR_LEFT);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_RIGHT, kta_pkg::VAL_PRESS, 1'b1,
                kta_pkg::CHAR_RIGHT);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_ENTER, kta_pkg::VAL_PRESS, 1'b1,
                kta_pkg::CHAR_LF);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_SPACE, kta_pkg::VAL_PRESS, 1'b1,
                kta_pkg::CHAR_SPACE);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_ESC, kta_pkg::VAL_PRESS, 1'b1,
                kta_pkg::CHAR_ESC);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_LSHIFT, kta_pkg::VAL_PRESS, 1'b1, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, KEY_1, kta_pkg::VAL_PRESS, 1'b0, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, KEY_SLASH, kta_pkg::VAL_PRESS, 1'b0, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_LSHIFT, VAL_RELEASE, 1'b1, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_RSHIFT, VAL_REPEAT, 1'b1, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, KEY_Q, VAL_REPEAT, 1'b1, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, KEY_Q, kta_pkg::VAL_PRESS, 1'b0, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_LCTRL, VAL_MAX, 1'b1, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, KEY_Z, kta_pkg::VAL_PRESS, 1'b0, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, KEY_1, kta_pkg::VAL_PRESS, 1'b1, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_UP, kta_pkg::VAL_PRESS, 1'b1,
                kta_pkg::CHAR_UP);
        add_row(kta_pkg::EVT_KEY, kta_pkg::CODE_RCTRL, VAL_RELEASE, 1'b1, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, KEY_ROM_LAST, kta_pkg::VAL_PRESS, 1'b1, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, KEY_ROM_OUT, kta_pkg::VAL_PRESS, 1'b1, CHAR_NONE);
        add_row(kta_pkg::EVT_KEY, KEY_MAX, kta_pkg::VAL_PRESS, 1'b1, CHAR_NONE);

        foreach (key_rows[i])
            send_request(key_rows[i].ev, key_rows[i].code, key_rows[i].val,
                         key_rows[i].typed, key_rows[i].ch);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 48; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 48; end
                default: begin sender_idle_pct = 24; stall_pct = 24; end
            endcase
            sent_reqs = 0;
            while (sent_reqs < REQS_PER_PHASE) begin
                random_request(ev, code, val);
                send_request(ev, code, val, 1'b0, CHAR_NONE);
                sent_reqs++;
            end
            // drop valid and let every pending char drain before the next phase
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (char_expect_q.size() != 0)
                @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests (%0d key events, %0d with fixed answers), %0d chars",
                 requests_sent, key_requests, typed_checks, chars_seen);
        $display("idle phases: none, sender 48%%, receiver 48%%, both 24%%; %0d cycles",
                 cycle_count);
        if (mismatches == 0 && char_expect_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/kta_pkg.sv
rtl/kta_xlate.sv
rtl/keycode_to_ascii_translator_top.sv
tb/tb_keycode_to_ascii_translator_top.sv
